@@ hdl/hysteretic_friction_damper_top_macros.svh @@
// Assertion macros shared by the friction damper RTL.
`ifndef HYSTERETIC_FRICTION_DAMPER_TOP_MACROS_SVH
`define HYSTERETIC_FRICTION_DAMPER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while reset is asserted.
`define HFD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while reset is asserted.
`define HFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/hfd_pkg.sv @@
// Package with widths, constants and register codes of the friction damper.
`default_nettype none

package hfd_pkg;

	// Field and datapath widths.
	localparam int DISP_W  = 32;
	localparam int FORCE_W = 48;
	localparam int CFG_W   = 32;
	localparam int LIM_W   = 31;
	localparam int MUL_W   = 32;
	localparam int FRAC_BITS = 24;
	localparam int SUM_W   = 42;
	localparam int SHP_W   = 2 * MUL_W - FRAC_BITS;

	// Saturation bounds of the hardening factor magnitude, signed Q8.24.
	localparam logic [SHP_W-1:0] H_POS_MAX = SHP_W'(32'h7FFF_FFFF);
	localparam logic [SHP_W-1:0] H_NEG_MAX = SHP_W'(33'h1_0000_0000) >> 1;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_YIELD_LIMIT  = 2'd0,
		CFG_PLASTIC_LIMIT = 2'd1,
		CFG_INV_SPAN     = 2'd2,
		CFG_FRICTION_GAIN = 2'd3
	} cfg_idx_t;

endpackage

`default_nettype wire

@@ hdl/hfd_channels.sv @@
// Stream channel interfaces of the friction damper: displacement in, force out.
`default_nettype none

interface hfd_disp_if import hfd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DISP_W-1:0] displacement;

	modport source (output valid, output displacement, input ready);
	modport sink (input valid, input displacement, output ready);
endinterface

interface hfd_force_if import hfd_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [FORCE_W-1:0] force_res;

	modport source (output valid, output force_res, input ready);
	modport sink (input valid, input force_res, output ready);
endinterface

`default_nettype wire

@@ hdl/hysteretic_friction_damper_top.sv @@
// Friction damper top level: sequencer, state registers and configuration.
//
// Usage: displacement samples (signed Q8.24) arrive on disp_chan, one per
// transaction; each produces exactly one friction force (signed Q32.16) on
// force_chan. Registers are written through cfg_we / cfg_index / cfg_data
// while the block is idle; the write takes effect at the next clock edge.
// After the accepting edge a sample steps through ST_CHECK, ST_CLAMP, ST_FSET,
// ST_FMUL and ST_FOUT when the hysteretic variable takes the full increment, and
// also through ST_MULH, ST_HSAT, ST_MULP and ST_ADDP before ST_CLAMP when the
// hardening factor has to be formed. disp_chan.ready rises at the edge that
// presents the force, so the next sample can be accepted in the cycle after;
// no new sample is taken while one is in progress. The sequence is set by the
// single 32x32 multiplier, used up to three times per sample (hardening factor,
// scaled increment, force), each pass through an operand and a product register.
// Reset (arst_n low) clears the hysteretic variable, the previous
// displacement, the configuration registers and any pending result.
// A stalled receiver holds the force in the output register; the next sample
// may be accepted and processed meanwhile, and it waits at the final step
// until the held force has been taken.
`default_nettype none

`include "hysteretic_friction_damper_top_macros.svh"

module hysteretic_friction_damper_top import hfd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	hfd_disp_if.sink              disp_chan,
	hfd_force_if.source           force_chan,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MULH,
		ST_HSAT,
		ST_MULP,
		ST_ADDP,
		ST_CLAMP,
		ST_FSET,
		ST_FMUL,
		ST_FOUT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [LIM_W-1:0] yield_q;
	logic [LIM_W-1:0] plastic_q;
	logic [MUL_W-1:0] span_q;
	logic [MUL_W-1:0] gain_q;

	// Model state.
	logic signed [DISP_W-1:0] q_q;
	logic signed [DISP_W-1:0] prev_q;

	// Per-sample working registers.
	logic signed [DISP_W:0]    d_q;
	logic signed [SUM_W-1:0]   qsum_q;
	logic [MUL_W-1:0]          ma_q;
	logic [MUL_W-1:0]          mb_q;
	logic                      diff_neg_q;
	logic                      pneg_q;
	logic                      fneg_q;
	logic signed [FORCE_W-1:0] force_q;
	logic                      out_valid_q;

	logic [2*MUL_W-1:0] prod;

	// Combinational helpers.
	logic                    q_neg;
	logic                    q_zero;
	logic [DISP_W-1:0]       q_mag;
	logic                    d_neg;
	logic                    d_zero;
	logic [MUL_W-1:0]        d_mag;
	logic                    outward;
	logic                    elastic;
	logic signed [DISP_W:0]  diff;
	logic [DISP_W:0]         diff_neg_val;
	logic [MUL_W-1:0]        diff_mag;
	logic [DISP_W:0]         d_neg_val;
	logic signed [SUM_W-1:0] q_ext;
	logic signed [SUM_W-1:0] full_sum;
	logic [SHP_W-1:0]        shp;
	logic [MUL_W-1:0]        h_mag;
	logic                    h_neg;
	logic [SUM_W-1:0]        p_ext;
	logic signed [SUM_W-1:0] p_signed;
	logic signed [SUM_W-1:0] plim_ext;
	logic signed [SUM_W-1:0] nplim_ext;
	logic signed [SUM_W-1:0] clamped;
	logic [FORCE_W-1:0]      fmag_ext;
	logic signed [FORCE_W-1:0] force_val;
	logic                    fout_go;
	logic                    accept;
	logic                    q_in_range;

	hfd_mul u_mul (
		.clk  (clk),
		.a    (ma_q),
		.b    (mb_q),
		.prod (prod)
	);

	// Magnitudes and signs of the variable and the increment.
	assign q_neg   = q_q[DISP_W-1];
	assign q_zero  = (q_q == '0);
	assign q_mag   = q_neg ? (~q_q + DISP_W'(1)) : q_q;
	assign d_neg   = d_q[DISP_W];
	assign d_zero  = (d_q == '0);
	assign d_neg_val = ~d_q + (DISP_W+1)'(1);
	assign d_mag   = d_neg ? d_neg_val[MUL_W-1:0] : d_q[MUL_W-1:0];
	assign outward = (!q_neg && !q_zero && !d_neg && !d_zero) || (q_neg && d_neg);
	assign elastic = (q_mag <= {1'b0, yield_q});

	// Distance from the plastic limit, as sign and magnitude.
	assign diff         = $signed({2'b00, plastic_q}) - $signed({1'b0, q_mag});
	assign diff_neg_val = ~diff + (DISP_W+1)'(1);
	assign diff_mag     = diff[DISP_W] ? diff_neg_val[MUL_W-1:0] : diff[MUL_W-1:0];

	// Full-step sum.
	assign q_ext    = SUM_W'(q_q);
	assign full_sum = q_ext + SUM_W'(d_q);

	// Hardening factor: truncated product, saturated to signed Q8.24.
	assign shp = prod[2*MUL_W-1:FRAC_BITS];
	always_comb begin
		if (diff_neg_q) begin
			h_mag = (shp > H_NEG_MAX) ? H_NEG_MAX[MUL_W-1:0] : shp[MUL_W-1:0];
		end else begin
			h_mag = (shp > H_POS_MAX) ? H_POS_MAX[MUL_W-1:0] : shp[MUL_W-1:0];
		end
	end
	assign h_neg = diff_neg_q && (shp != '0);

	// Scaled increment with its sign applied.
	assign p_ext    = SUM_W'(shp);
	assign p_signed = pneg_q ? $signed(~p_ext + SUM_W'(1)) : $signed(p_ext);

	// Clamp to plus or minus the plastic limit.
	assign plim_ext  = $signed(SUM_W'(plastic_q));
	assign nplim_ext = -plim_ext;
	always_comb begin
		priority if (qsum_q > plim_ext) begin
			clamped = plim_ext;
		end else if (qsum_q < nplim_ext) begin
			clamped = nplim_ext;
		end else begin
			clamped = qsum_q;
		end
	end

	// Force is minus gain times the variable; the 40-bit magnitude never
	// reaches the 48-bit saturation bounds.
	assign fmag_ext  = FORCE_W'(shp);
	assign force_val = fneg_q ? $signed(fmag_ext) : $signed(~fmag_ext + FORCE_W'(1));

	assign fout_go = !out_valid_q || force_chan.ready;
	assign accept  = disp_chan.valid && disp_chan.ready;

	// Handshake outputs.
	assign disp_chan.ready    = (state_q == ST_IDLE);
	assign force_chan.valid   = out_valid_q;
	assign force_chan.force_res = force_q;

	// Sequencer, model state, configuration and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			q_q         <= '0;
			prev_q      <= '0;
			yield_q     <= '0;
			plastic_q   <= '0;
			span_q      <= '0;
			gain_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_YIELD_LIMIT:   yield_q   <= cfg_data[LIM_W-1:0];
					CFG_PLASTIC_LIMIT: plastic_q <= cfg_data[LIM_W-1:0];
					CFG_INV_SPAN:      span_q    <= cfg_data;
					CFG_FRICTION_GAIN: gain_q    <= cfg_data;
				endcase
			end

			// A new force is loaded, or a taken one is retired.
			if ((state_q == ST_FOUT) && fout_go) begin
				out_valid_q <= 1'b1;
			end else if (force_chan.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prev_q  <= disp_chan.displacement;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (elastic || !outward) begin
						state_q <= ST_CLAMP;
					end else begin
						state_q <= ST_MULH;
					end
				end
				ST_MULH:  state_q <= ST_HSAT;
				ST_HSAT:  state_q <= ST_MULP;
				ST_MULP:  state_q <= ST_ADDP;
				ST_ADDP:  state_q <= ST_CLAMP;
				ST_CLAMP: begin
					q_q     <= clamped[DISP_W-1:0];
					state_q <= ST_FSET;
				end
				ST_FSET:  state_q <= ST_FMUL;
				ST_FMUL:  state_q <= ST_FOUT;
				ST_FOUT: begin
					if (fout_go) begin
						state_q <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					d_q <= (DISP_W+1)'(disp_chan.displacement) - (DISP_W+1)'(prev_q);
				end
			end
			ST_CHECK: begin
				qsum_q     <= full_sum;
				ma_q       <= diff_mag;
				mb_q       <= span_q;
				diff_neg_q <= diff[DISP_W];
			end
			ST_HSAT: begin
				ma_q   <= d_mag;
				mb_q   <= h_mag;
				pneg_q <= d_neg ^ h_neg;
			end
			ST_ADDP: begin
				qsum_q <= q_ext + p_signed;
			end
			ST_FSET: begin
				ma_q   <= q_mag;
				mb_q   <= gain_q;
				fneg_q <= q_neg;
			end
			ST_FOUT: begin
				if (fout_go) begin
					force_q <= force_val;
				end
			end
			default: begin
			end
		endcase
	end

	// Checks on the sequencer and the clamp.
	assign q_in_range = (q_q <= $signed({1'b0, plastic_q}))
		&& (q_q >= -$signed({1'b0, plastic_q}));

	`HFD_ASSERT_IMPL(a_clamp_range, state_q == ST_FSET, q_in_range, "variable outside plastic limit")
	`HFD_ASSERT_NEXT(a_prev_capture, accept, (prev_q == $past(disp_chan.displacement)) && (state_q == ST_CHECK), "sample not captured")
	`HFD_ASSERT_NEXT(a_result_issue, (state_q == ST_FOUT) && fout_go, out_valid_q && (state_q == ST_IDLE), "result not issued")

endmodule

`default_nettype wire

@@ hdl/hfd_mul.sv @@
// Shared unsigned multiplier with a registered product.
`default_nettype none

module hfd_mul import hfd_pkg::*; (
	input  wire logic               clk,
	input  wire logic [MUL_W-1:0]   a,
	input  wire logic [MUL_W-1:0]   b,
	output logic      [2*MUL_W-1:0] prod
);

	logic [2*MUL_W-1:0] prod_s1;

	// One full-width product per cycle, registered.
	always_ff @(posedge clk) begin
		prod_s1 <= (2*MUL_W)'(a) * (2*MUL_W)'(b);
	end

	assign prod = prod_s1;

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench of the hysteretic friction damper, with directed and random samples.
module tb_top;
	import hfd_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 5;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 24;
	localparam int LONG_HOLD     = 300;
	localparam int LONG_HOLD_AT  = 120;
	localparam int PHASE_ITEMS   = 80;

	localparam longint H_SAT_HI     = 64'sd2147483647;
	localparam longint H_SAT_LO     = -64'sd2147483648;
	localparam longint FORCE_SAT_HI = 64'sd140737488355327;
	localparam longint FORCE_SAT_LO = -64'sd140737488355328;

	typedef longint unsigned u64_t;

	// One row of the directed part: a register write or a displacement sample.
	typedef enum {ROW_WRITE, ROW_SAMPLE} row_kind_t;
	typedef struct {
		row_kind_t                 kind;
		cfg_idx_t                  idx;
		logic [CFG_W-1:0]          value;
		bit                        typed;
		logic signed [FORCE_W-1:0] force_val;
	} dir_row_t;

	// Register settings used by the random phases.
	typedef enum {PH_HYSTERESIS, PH_ALL_ONES, PH_ANY_BITS, PH_NO_HARDENING} phase_kind_t;

	localparam int N_DIR = 39;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	cfg_idx_t         cfg_index;
	logic [CFG_W-1:0] cfg_data;

	hfd_disp_if  disp_chan ();
	hfd_force_if force_chan ();

	hysteretic_friction_damper_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.disp_chan(disp_chan),
		.force_chan(force_chan),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow registers and state of the damper as the testbench predicts them.
	logic [LIM_W-1:0] yield_lim   = '0;
	logic [LIM_W-1:0] plastic_lim = '0;
	logic [CFG_W-1:0] inv_span    = '0;
	logic [CFG_W-1:0] fric_gain   = '0;
	longint           hyst_q      = 0;
	longint           last_disp   = 0;

	logic signed [FORCE_W-1:0] force_expected [$];
	logic signed [FORCE_W-1:0] force_want;

	int err_count   = 0;
	int cycle_count = 0;
	int forces_seen = 0;
	int burst_left  = 0;
	bit sending     = 1'b0;

	// Directed samples. Expected forces are typed in where they follow directly:
	// zero plastic limit, and a unit gain with a one-unit elastic range.
	dir_row_t dir_rows [N_DIR] = '{
		'{ROW_SAMPLE, CFG_YIELD_LIMIT,   32'h7FFF_FFFF, 1'b1, 48'sd0},
		'{ROW_SAMPLE, CFG_YIELD_LIMIT,   32'h8000_0000, 1'b1, 48'sd0},
		'{ROW_SAMPLE, CFG_YIELD_LIMIT,   32'h0000_0000, 1'b1, 48'sd0},
		'{ROW_WRITE,  CFG_FRICTION_GAIN, 32'h0001_0000, 1'b0, 48'sd0},
		'{ROW_WRITE,  CFG_YIELD_LIMIT,   32'h0100_0000, 1'b0, 48'sd0},
		'{ROW_WRITE,  CFG_PLASTIC_LIMIT, 32'h0200_0000, 1'b0, 48'sd0},
		'{ROW_WRITE,  CFG_INV_SPAN,      32'h0100_0000, 1'b0, 48'sd0},
		'{ROW_SAMPLE, CFG_YIELD_LIMIT,   32'h0080_0000, 1'b1, -48'sd32768},
		'{ROW_SAMPLE, CFG_YIELD_LIMIT,   32'h0180_0000, 1'b1, -48'sd98304},
		'{ROW_SAMPLE, CFG_YIELD_LIMIT,   32'h0280_0000, 1'b1, -48'sd131072},
		'{ROW_SAMPLE, CFG_YIELD_LIMIT,   32'h0380_0000, 1'b1, -48'sd131072},
		'{ROW_SAMPLE, CFG_YIELD_LIMIT,   32'h0200_0000, 1'b1, -48'sd32768},
		'{ROW_SAMPLE, CFG_YIELD_LIMIT,   32'h8000_0000, 1'b1, 48'sd131072},
		'{ROW_SAMPLE, CFG_YIELD_LIMIT,   32'h7FFF_FFFF, 1'b1, -48'sd131072},
		'{ROW_WRITE,  CFG_YIELD_LIMIT,   32'hFFFF_FFFF, 1'b0, 48'sd0},
		'{ROW_SAMPLE, CFG_YIELD_LIMIT,   32'h0000_0000, 1'b1, 48'sd131072},
		'{ROW_SAMPLE, CFG_YIELD_LIMIT,   32'h0100_0000, 1'b0, 48'sd0},
		'{ROW_WRITE,  CFG_YIELD_LIMIT,   32'h0000_0000, 1'b0, 48'sd0},
		'{ROW_WRITE,  CFG_PLASTIC_LIMIT, 32'h0080_0000, 1'b0, 48'sd0},
		'{ROW_SAMPLE, CFG_YIELD_LIMIT,   32'h00F0_0000, 1'b0, 48'sd0},
		'{ROW_SAMPLE, CFG_YIELD_LIMIT,   32'h0000_0000, 1'b0, 48'sd0},
		'{ROW_WRITE,  CFG_INV_SPAN,      32'h0000_0000, 1'b0, 48'sd0},
		'{ROW_WRITE,  CFG_PLASTIC_LIMIT, 32'h0200_0000, 1'b0, 48'sd0},
		'{ROW_WRITE,  CFG_YIELD_LIMIT,   32'h0040_0000, 1'b0, 48'sd0},
		'{ROW_SAMPLE, CFG_YIELD_LIMIT,   32'h0100_0000, 1'b0, 48'sd0},
		'{ROW_SAMPLE, CFG_YIELD_LIMIT,   32'h0200_0000, 1'b0, 48'sd0},
		'{ROW_SAMPLE, CFG_YIELD_LIMIT,   32'h0300_0000, 1'b0, 48'sd0},
		'{ROW_WRITE,  CFG_PLASTIC_LIMIT, 32'h7FFF_FFFF, 1'b0, 48'sd0},
		'{ROW_WRITE,  CFG_YIELD_LIMIT,   32'h0000_0000, 1'b0, 48'sd0},
		'{ROW_WRITE,  CFG_INV_SPAN,      32'hFFFF_FFFF, 1'b0, 48'sd0},
		'{ROW_WRITE,  CFG_FRICTION_GAIN, 32'hFFFF_FFFF, 1'b0, 48'sd0},
		'{ROW_SAMPLE, CFG_YIELD_LIMIT,   32'h7FFF_FFFF, 1'b0, 48'sd0},
		'{ROW_SAMPLE, CFG_YIELD_LIMIT,   32'h8000_0000, 1'b0, 48'sd0},
		'{ROW_SAMPLE, CFG_YIELD_LIMIT,   32'h7FFF_FFFF, 1'b0, 48'sd0},
		'{ROW_SAMPLE, CFG_YIELD_LIMIT,   32'h0000_0001, 1'b0, 48'sd0},
		'{ROW_SAMPLE, CFG_YIELD_LIMIT,   32'hFFFF_FFFF, 1'b0, 48'sd0},
		'{ROW_WRITE,  CFG_PLASTIC_LIMIT, 32'h0000_0000, 1'b0, 48'sd0},
		'{ROW_SAMPLE, CFG_YIELD_LIMIT,   32'h1234_5678, 1'b1, 48'sd0},
		'{ROW_SAMPLE, CFG_YIELD_LIMIT,   32'h8000_0000, 1'b1, 48'sd0}
	};

	// Free-running clock.
	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	function automatic u64_t magnitude(input longint v);
		return (v < 0) ? u64_t'(-v) : u64_t'(v);
	endfunction

	// Signed value times an unsigned Q.24 factor, truncated toward zero.
	function automatic longint scale_q24(input longint a, input u64_t b);
		u64_t p;
		p = (magnitude(a) * b) >> FRAC_BITS;
		return (a < 0) ? -longint'(p) : longint'(p);
	endfunction

	// Applies one displacement sample to the predicted state and returns the force.
	function automatic logic signed [FORCE_W-1:0] advance_damper(
		input logic signed [DISP_W-1:0] disp
	);
		longint step;
		longint q;
		longint lim;
		longint h;
		longint f;
		bit     outward;
		step    = longint'(disp) - last_disp;
		q       = hyst_q;
		lim     = longint'(plastic_lim);
		outward = (q > 0 && step > 0) || (q < 0 && step < 0);
		if (magnitude(q) <= u64_t'(yield_lim) || !outward) begin
			q = q + step;
		end else begin
			// Hardening factor falls linearly to zero at the plastic limit.
			h = scale_q24(lim - longint'(magnitude(q)), u64_t'(inv_span));
			if (h > H_SAT_HI)
				h = H_SAT_HI;
			if (h < H_SAT_LO)
				h = H_SAT_LO;
			if (h < 0)
				q = q - scale_q24(step, magnitude(h));
			else
				q = q + scale_q24(step, magnitude(h));
		end
		if (q > lim)
			q = lim;
		else if (q < -lim)
			q = -lim;
		hyst_q    = q;
		last_disp = longint'(disp);
		f = -scale_q24(q, u64_t'(fric_gain));
		if (f > FORCE_SAT_HI)
			f = FORCE_SAT_HI;
		if (f < FORCE_SAT_LO)
			f = FORCE_SAT_LO;
		return f[FORCE_W-1:0];
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		err_count++;
	endtask

	// Drops valid if a transaction is still being offered.
	task automatic release_chan();
		if (sending) begin
			disp_chan.valid <= 1'b0;
			sending = 1'b0;
		end
	endtask

	// Waits until every expected force has arrived and the block has settled.
	task automatic wait_idle();
		release_chan();
		while (force_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_we high; the caller lowers it after the last write of a group.
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			CFG_YIELD_LIMIT:   yield_lim   = value[LIM_W-1:0];
			CFG_PLASTIC_LIMIT: plastic_lim = value[LIM_W-1:0];
			CFG_INV_SPAN:      inv_span    = value;
			CFG_FRICTION_GAIN: fric_gain   = value;
			default: ;
		endcase
	endtask

	// Offers one sample in bursts with random gaps, and records its expected force.
	task automatic send_sample(
		input logic signed [DISP_W-1:0]  disp,
		input bit                        typed,
		input logic signed [FORCE_W-1:0] typed_force
	);
		int                        gap;
		logic signed [FORCE_W-1:0] predicted;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				release_chan();
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		disp_chan.valid        <= 1'b1;
		disp_chan.displacement <= disp;
		sending = 1'b1;
		do
			@(posedge clk);
		while (!disp_chan.ready);
		burst_left--;
		predicted = advance_damper(disp);
		force_expected.push_back(typed ? typed_force : predicted);
	endtask

	// One random phase: program a register setting, then drive a displacement walk.
	task automatic run_phase(input phase_kind_t kind, input int n_items);
		logic [CFG_W-1:0]         y;
		logic [CFG_W-1:0]         p;
		logic [CFG_W-1:0]         s;
		logic [CFG_W-1:0]         g;
		u64_t                     span;
		u64_t                     ratio;
		logic signed [DISP_W-1:0] pos;
		int                       amp;
		int                       step;
		int                       heading;
		int                       pick;
		case (kind)
			PH_HYSTERESIS: begin
				y     = $urandom_range(0, 1 << 26);
				span  = $urandom_range(1, 1 << 26);
				p     = y + span[CFG_W-1:0];
				ratio = (64'd1 << 48) / span;
				s     = (ratio > 64'hFFFF_FFFF) ? '1 : ratio[CFG_W-1:0];
				g     = $urandom_range(1 << 12, 1 << 20);
			end
			PH_ALL_ONES: begin
				y = '1;
				p = '1;
				s = '1;
				g = '1;
			end
			PH_ANY_BITS: begin
				y = $urandom;
				p = $urandom;
				s = $urandom;
				g = $urandom;
			end
			default: begin
				y = $urandom_range(0, 1 << 24);
				p = y + $urandom_range(1 << 22, 1 << 25);
				s = '0;
				g = $urandom;
			end
		endcase
		wait_idle();
		write_reg(CFG_YIELD_LIMIT, y);
		write_reg(CFG_PLASTIC_LIMIT, p);
		write_reg(CFG_INV_SPAN, s);
		write_reg(CFG_FRICTION_GAIN, g);
		cfg_we <= 1'b0;

		// Mostly a walk that turns around now and then, so that the variable
		// yields and saturates; some repeated and some arbitrary positions.
		pos     = last_disp[DISP_W-1:0];
		heading = 1;
		amp     = (plastic_lim > (1 << 28)) ? (1 << 27) : int'(plastic_lim >> 1) + (1 << 16);
		for (int k = 0; k < n_items; k++) begin
			if ($urandom_range(0, 7) == 0)
				heading = -heading;
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				pos = $urandom;
			end else if (pick >= 3) begin
				step = $urandom_range(0, amp);
				pos  = (heading > 0) ? pos + step : pos - step;
			end
			send_sample(pos, 1'b0, '0);
		end
	endtask

	// Cycle count and run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Force checker: each accepted transaction is matched against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && force_chan.valid && force_chan.ready) begin
			forces_seen <= forces_seen + 1;
			if (force_expected.size() == 0) begin
				flag_mismatch($sformatf("unexpected force %0d", force_chan.force_res));
			end else begin
				force_want = force_expected.pop_front();
				if (force_chan.force_res !== force_want)
					flag_mismatch($sformatf("force got %0d, expected %0d",
						force_chan.force_res, force_want));
			end
		end
	end

	// Receiver: ready share follows cycle_count[10:9], plus one long hold-off
	// that lets the block fill up and back-pressure the sender.
	initial begin : receiver
		int hold_left;
		bit hold_done;
		int share;
		hold_left = 0;
		hold_done = 1'b0;
		force_chan.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!hold_done && forces_seen >= LONG_HOLD_AT) begin
				hold_left = LONG_HOLD;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				force_chan.ready <= 1'b0;
			end else begin
				share = int'(cycle_count[10:9]) + 1;
				force_chan.ready <= ($urandom_range(0, 3) < share);
			end
		end
	end

	// Main sequence: reset, directed table, random phases, drain and verdict.
	initial begin : stimulus
		bit writing;
		writing = 1'b0;
		arst_n                 <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_index              <= CFG_YIELD_LIMIT;
		cfg_data               <= '0;
		disp_chan.valid        <= 1'b0;
		disp_chan.displacement <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; consecutive writes form one group while the block is idle.
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_WRITE) begin
				if (!writing) begin
					wait_idle();
					writing = 1'b1;
				end
				write_reg(dir_rows[i].idx, dir_rows[i].value);
			end else begin
				if (writing) begin
					cfg_we <= 1'b0;
					writing = 1'b0;
				end
				send_sample(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].force_val);
			end
		end

		run_phase(PH_HYSTERESIS, PHASE_ITEMS);
		run_phase(PH_ALL_ONES, PHASE_ITEMS);
		run_phase(PH_HYSTERESIS, PHASE_ITEMS);
		run_phase(PH_ANY_BITS, PHASE_ITEMS);
		run_phase(PH_NO_HARDENING, PHASE_ITEMS);
		run_phase(PH_HYSTERESIS, PHASE_ITEMS);

		release_chan();
		while (force_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
